/* hdl/bdll_pkg.sv */
// Shared types and constants for the bounded doubly linked list.
package bdll_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_BACK  = 3'd0,
        OP_ADD_FRONT = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_READ_FWD  = 3'd3,
        OP_READ_BWD  = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        SH_HOLD       = 3'd0,
        SH_PUSH_FRONT = 3'd1,
        SH_PUSH_BACK  = 3'd2,
        SH_REMOVE     = 3'd3,
        SH_ROT_FWD    = 3'd4,
        SH_ROT_BWD    = 3'd5
    } t_shift;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    typedef struct packed {
        t_shift                     op;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctl;

endpackage

/* hdl/bdll_cell.sv */
// One storage cell of the list chain: holds the element at its own position.
module bdll_cell
    import bdll_pkg::*;
#(
    parameter int CW = 5
) (
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic [CW-1:0]              i_index,
    input  logic [CW-1:0]              i_count,
    input  logic [CW-1:0]              i_cut,
    input  logic signed [VALUE_W-1:0]  i_left,
    input  logic signed [VALUE_W-1:0]  i_right,
    input  logic signed [VALUE_W-1:0]  i_head,
    input  logic signed [VALUE_W-1:0]  i_tail,
    output logic signed [VALUE_W-1:0]  o_value
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic [CW-1:0]             w_index_p1;

    assign w_index_p1 = i_index + CW'(1);

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            SH_HOLD: begin
                n_value = r_value;
            end
            SH_PUSH_FRONT: begin
                n_value = (i_index == '0) ? i_ctl.value : i_left;
            end
            SH_PUSH_BACK: begin
                if (i_index == i_count) begin
                    n_value = i_ctl.value;
                end
            end
            SH_REMOVE: begin
                // Cells at and after the removed position close the gap.
                if (i_index >= i_cut) begin
                    n_value = i_right;
                end
            end
            SH_ROT_FWD: begin
                if (w_index_p1 == i_count) begin
                    n_value = i_head;
                end else if (w_index_p1 < i_count) begin
                    n_value = i_right;
                end
            end
            SH_ROT_BWD: begin
                if (i_index == '0) begin
                    n_value = i_tail;
                end else if (i_index < i_count) begin
                    n_value = i_left;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* hdl/bounded_doubly_linked_list.sv */
// Top level of the bounded doubly linked list: request decode and the cell chain.
//
// This block keeps an ordered list of up to CAPACITY signed 32-bit values and
// answers one request at a time. The list is held in a chain of cells in list
// order, the first element in cell zero, so that an add at the front or a remove
// is a local shift between neighboring cells. Add at the back, add at the front,
// remove at a 1-based position and the unused opcodes each give one result. A
// forward or backward read-out gives one result per element: the chain rotates
// by one cell per cycle while the output is not stalled, and the element at the
// front (forward) or the back (backward) of the chain is sent out each time. The
// chain is back in its original order when the read-out ends. A read-out of an
// empty list gives a single result with status list empty. An add on a full
// list gives status list full, and a remove at position zero or above the count
// gives status invalid position; neither changes the list. Every result carries
// the element count after the request, and the last result of each request has
// last_of_run set. The output is registered, so a result may wait on a stalled
// output while the block still takes the next single-result request as soon as
// the register is taken. While a read-out is in progress the input is stalled.
// Reset is synchronous and active low and empties the list.
module bounded_doubly_linked_list
    import bdll_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [OPCODE_W-1:0]                  i_opcode,
    input  logic signed [VALUE_W-1:0]            i_item_value,
    input  logic [POS_W-1:0]                     i_position,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [VALUE_W-1:0]            o_element_value,
    output logic [STATUS_W-1:0]                  o_status,
    output logic [$clog2(CAPACITY+1)-1:0]        o_element_count,
    output logic                                 o_last_of_run
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Control state.
    t_state                     r_state;
    t_state                     n_state;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [CW-1:0]              r_left;
    logic [CW-1:0]              n_left;
    logic                       r_fwd;
    logic                       n_fwd;

    // Output register.
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic signed [VALUE_W-1:0]  n_out_value;
    t_status                    r_out_status;
    t_status                    n_out_status;
    logic [CW-1:0]              r_out_count;
    logic [CW-1:0]              n_out_count;
    logic                       r_out_last;
    logic                       n_out_last;

    // Chain wiring.
    t_cell_ctl                  w_ctl;
    logic [CW-1:0]              w_cut;
    logic signed [VALUE_W-1:0]  w_cell [CAPACITY];
    logic signed [VALUE_W-1:0]  w_tail;
    logic [IW-1:0]              w_tail_idx;
    logic                       w_out_free;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_bad_pos;

    // The output register can take a new result when it is empty or being taken.
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != ST_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_bad_pos  = (i_position == '0) || (i_position > POS_W'(r_count));
    assign w_cut      = CW'(i_position - POS_W'(1));

    // The tail cell sits at count minus one; it is only used while the list
    // holds at least one element.
    assign w_tail_idx = IW'(r_count - CW'(1));
    assign w_tail     = w_cell[w_tail_idx];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_left       = r_left;
        n_fwd        = r_fwd;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        w_ctl.op     = SH_HOLD;
        w_ctl.value  = i_item_value;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // Single-result requests load the output register now.
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = STAT_OK;
                    n_out_last   = 1'b1;
                    n_out_count  = r_count;
                    unique case (t_opcode'(i_opcode))
                        OP_ADD_BACK, OP_ADD_FRONT: begin
                            if (w_full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                w_ctl.op    = (t_opcode'(i_opcode) == OP_ADD_FRONT)
                                              ? SH_PUSH_FRONT : SH_PUSH_BACK;
                                n_count     = r_count + CW'(1);
                                n_out_count = r_count + CW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (w_bad_pos) begin
                                n_out_status = STAT_BADPOS;
                            end else begin
                                w_ctl.op    = SH_REMOVE;
                                n_count     = r_count - CW'(1);
                                n_out_count = r_count - CW'(1);
                            end
                        end
                        OP_READ_FWD, OP_READ_BWD: begin
                            if (r_count == '0) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                // Results come from the read-out state instead.
                                n_out_valid = 1'b0;
                                n_state     = ST_READ;
                                n_left      = r_count;
                                n_fwd       = (t_opcode'(i_opcode) == OP_READ_FWD);
                            end
                        end
                        default: begin
                            n_out_status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_fwd ? w_cell[0] : w_tail;
                    n_out_status = STAT_OK;
                    n_out_count  = r_count;
                    n_out_last   = (r_left == CW'(1));
                    w_ctl.op     = r_fwd ? SH_ROT_FWD : SH_ROT_BWD;
                    n_left       = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd        <= n_fwd;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    // The chain of cells; the ends see zero from beyond the chain.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left;
        logic signed [VALUE_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_cell[g+1];
        end

        bdll_cell #(
            .CW(CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (CW'(g)),
            .i_count (r_count),
            .i_cut   (w_cut),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cell[0]),
            .i_tail  (w_tail),
            .o_value (w_cell[g])
        );
    end

    assign o_valid         = r_out_valid;
    assign o_element_value = r_out_value;
    assign o_status        = r_out_status;
    assign o_element_count = r_out_count;
    assign o_last_of_run   = r_out_last;

endmodule

/* sim/bounded_doubly_linked_list_test.sv */
// Self-checking testbench for the bounded doubly linked list, checked against a queue-based list predictor.
`timescale 1ns / 100ps

module bounded_doubly_linked_list_test;
    import bdll_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int COUNT_W          = $clog2(CAPACITY + 1);
    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_PER_PHASE = 34;
    localparam int NUM_PHASES       = 3;
    // The long output hold-off lets the output register fill and the input stall behind it.
    localparam int HOLDOFF_CYCLES   = 150;
    // Longest quiet stretch of a correct run is the hold-off; allow many times that.
    localparam int QUIET_LIMIT      = 2000;
    // After the last expected result, keep watching for stray results.
    localparam int DRAIN_CYCLES     = 2 * CAPACITY + 8;
    localparam int MAX_PRINTED      = 40;
    localparam int NUM_DIRECTED     = 25;

    // The opcodes the package leaves unnamed; the block must answer them with a plain ok.
    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_C = 3'd7;

    // One result as the block should deliver it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        t_status                   status;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_result;

    // One row of the directed table. A row is sent reps times, with the value stepped by one
    // on each repeat. Where typed is set, the expected single result is written in the row.
    typedef struct packed {
        logic [OPCODE_W-1:0]       op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
        logic [4:0]                reps;
        logic                      typed;
        t_status                   status;
        logic [COUNT_W-1:0]        count;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [OPCODE_W-1:0]           i_opcode;
    logic signed [VALUE_W-1:0]     i_item_value;
    logic [POS_W-1:0]              i_position;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [VALUE_W-1:0]     o_element_value;
    logic [STATUS_W-1:0]           o_status;
    logic [COUNT_W-1:0]            o_element_count;
    logic                          o_last_of_run;

    // Predictor state: the list in order, first element at index zero.
    logic signed [VALUE_W-1:0]     list_contents[$];
    // Results owed by the block, oldest first.
    t_result                       pending_results[$];

    int                            mismatches;
    int                            send_idle_pct;
    int                            recv_idle_pct;
    int                            quiet_cycles;
    bit                            holdoff_armed;
    bit                            holdoff_used;
    int                            holdoff_left;

    // The directed table: empty-list cases first, then the value extremes, bad positions
    // (zero, past the end, 255), the unused opcodes, a fill to capacity with adds refused at
    // full, removal of head, tail and a middle entry, and finally a one-element list removed.
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{OP_READ_FWD,  32'sd0,            8'd0,   5'd1,  1'b1, STAT_EMPTY,  5'd0},
        '{OP_REMOVE,    32'sd0,            8'd1,   5'd1,  1'b1, STAT_BADPOS, 5'd0},
        '{OP_ADD_BACK,  32'sh7FFF_FFFF,    8'd0,   5'd1,  1'b1, STAT_OK,     5'd1},
        '{OP_ADD_FRONT, 32'sh8000_0000,    8'd0,   5'd1,  1'b1, STAT_OK,     5'd2},
        '{OP_READ_FWD,  32'sd0,            8'd0,   5'd1,  1'b0, STAT_OK,     5'd0},
        '{OP_READ_BWD,  32'sd0,            8'd0,   5'd1,  1'b0, STAT_OK,     5'd0},
        '{OP_REMOVE,    32'sd0,            8'd0,   5'd1,  1'b1, STAT_BADPOS, 5'd2},
        '{OP_REMOVE,    32'sd0,            8'd3,   5'd1,  1'b1, STAT_BADPOS, 5'd2},
        '{OP_REMOVE,    32'sd0,            8'd255, 5'd1,  1'b1, STAT_BADPOS, 5'd2},
        '{OP_SPARE_A,   -32'sd1,           8'd255, 5'd1,  1'b1, STAT_OK,     5'd2},
        '{OP_SPARE_B,   32'sh5555_5555,    8'd1,   5'd1,  1'b1, STAT_OK,     5'd2},
        '{OP_SPARE_C,   32'shAAAA_AAAA,    8'd2,   5'd1,  1'b1, STAT_OK,     5'd2},
        '{OP_ADD_BACK,  32'sd0,            8'd0,   5'd1,  1'b1, STAT_OK,     5'd3},
        '{OP_ADD_BACK,  32'sh1234_0000,    8'd0,   5'd13, 1'b0, STAT_OK,     5'd0},
        '{OP_ADD_FRONT, 32'sd1,            8'd0,   5'd1,  1'b1, STAT_FULL,   5'd16},
        '{OP_ADD_BACK,  32'sd2,            8'd0,   5'd1,  1'b1, STAT_FULL,   5'd16},
        '{OP_READ_FWD,  32'sd0,            8'd0,   5'd1,  1'b0, STAT_OK,     5'd0},
        '{OP_REMOVE,    32'sd0,            8'd1,   5'd1,  1'b1, STAT_OK,     5'd15},
        '{OP_REMOVE,    32'sd0,            8'd15,  5'd1,  1'b1, STAT_OK,     5'd14},
        '{OP_REMOVE,    32'sd0,            8'd7,   5'd1,  1'b1, STAT_OK,     5'd13},
        '{OP_READ_BWD,  32'sd0,            8'd0,   5'd1,  1'b0, STAT_OK,     5'd0},
        '{OP_REMOVE,    32'sd0,            8'd1,   5'd13, 1'b0, STAT_OK,     5'd0},
        '{OP_READ_BWD,  32'sd0,            8'd0,   5'd1,  1'b1, STAT_EMPTY,  5'd0},
        '{OP_ADD_FRONT, 32'sh5A5A_A5A5,    8'd0,   5'd1,  1'b1, STAT_OK,     5'd1},
        '{OP_REMOVE,    32'sd0,            8'd1,   5'd1,  1'b1, STAT_OK,     5'd0}
    };

    bounded_doubly_linked_list #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_element_value (o_element_value),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Prints one line per mismatch, up to a cap, and always counts it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Applies one request to the list predictor and queues the results it owes.
    // A read-out owes one result per element, the last one flagged; everything else owes one.
    task automatic apply_list_op(input logic [OPCODE_W-1:0] op,
                                 input logic signed [VALUE_W-1:0] value,
                                 input logic [POS_W-1:0] pos);
        t_result res;
        int      n;
        res = '{value: '0, status: STAT_OK, count: '0, last: 1'b1};
        case (op)
            OP_ADD_BACK, OP_ADD_FRONT: begin
                if (list_contents.size() >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else if (op == OP_ADD_FRONT) begin
                    list_contents.push_front(value);
                end else begin
                    list_contents.push_back(value);
                end
            end
            OP_REMOVE: begin
                if (pos == 0 || pos > list_contents.size()) begin
                    res.status = STAT_BADPOS;
                end else begin
                    list_contents.delete(int'(pos) - 1);
                end
            end
            OP_READ_FWD, OP_READ_BWD: begin
                if (list_contents.size() == 0) begin
                    res.status = STAT_EMPTY;
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(list_contents.size());
        n = list_contents.size();
        if ((op == OP_READ_FWD || op == OP_READ_BWD) && n != 0) begin
            for (int k = 0; k < n; k++) begin
                res.value = (op == OP_READ_FWD) ? list_contents[k] : list_contents[n - 1 - k];
                res.last  = (k == n - 1);
                pending_results.push_back(res);
            end
        end else begin
            pending_results.push_back(res);
        end
    endtask

    // Offers one request, with random idle cycles ahead of it, and waits until it is taken.
    // Valid stays high after acceptance so back-to-back requests need no extra edge.
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] pos,
                                input logic typed,
                                input t_status want_status,
                                input logic [COUNT_W-1:0] want_count);
        t_result typed_result;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_item_value <= value;
        i_position   <= pos;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        apply_list_op(op, value, pos);
        if (typed) begin
            // The row states the answer directly; it replaces the predicted single result.
            typed_result = pending_results.pop_back();
            typed_result.status = want_status;
            typed_result.count  = want_count;
            pending_results.push_back(typed_result);
        end
    endtask

    // Receiver stall: random per the current phase, except during the one long hold-off.
    always @(negedge i_clk) begin
        if (holdoff_armed && !holdoff_used) begin
            holdoff_used = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker: every taken result is compared field by field with the oldest owed one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected, value", o_element_value, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_element_value !== want.value) begin
                    report_mismatch("element_value", o_element_value, want.value);
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
                if (o_element_count !== want.count) begin
                    report_mismatch("element_count", o_element_count, want.count);
                end
                if (o_last_of_run !== want.last) begin
                    report_mismatch("last_of_run", o_last_of_run, want.last);
                end
            end
        end
    end

    // Watchdog: a run in which nothing moves on either side for too long has hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [OPCODE_W-1:0]       op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
        int                        pick;
        int                        size_now;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_opcode      = OP_ADD_BACK;
        i_item_value  = '0;
        i_position    = '0;
        mismatches    = 0;
        quiet_cycles  = 0;
        holdoff_armed = 1'b0;
        holdoff_used  = 1'b0;
        holdoff_left  = 0;
        send_idle_pct = 29;
        recv_idle_pct = 67;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the first idling mix.
        foreach (directed_rows[k]) begin
            for (int rep = 0; rep < int'(directed_rows[k].reps); rep++) begin
                send_request(directed_rows[k].op, directed_rows[k].value + rep,
                             directed_rows[k].pos, directed_rows[k].typed,
                             directed_rows[k].status, directed_rows[k].count);
            end
        end

        // Random part in three phases: sender mostly busy, then receiver mostly busy,
        // then no idling at all, with the long output hold-off at the start of the last.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    holdoff_armed = 1'b1;
                end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                size_now = list_contents.size();
                // Adds outweigh removes so the list climbs to capacity and stays near it,
                // which keeps read-outs long and makes full-list adds come up regularly.
                pick = $urandom_range(99);
                if (pick < 22) begin
                    op = OP_ADD_BACK;
                end else if (pick < 40) begin
                    op = OP_ADD_FRONT;
                end else if (pick < 68) begin
                    op = OP_REMOVE;
                end else if (pick < 78) begin
                    op = OP_READ_FWD;
                end else if (pick < 88) begin
                    op = OP_READ_BWD;
                end else if (pick < 93) begin
                    op = OP_SPARE_A;
                end else if (pick < 97) begin
                    op = OP_SPARE_B;
                end else begin
                    op = OP_SPARE_C;
                end

                pick = $urandom_range(9);
                if (pick == 0) begin
                    value = 32'sh7FFF_FFFF;
                end else if (pick == 1) begin
                    value = 32'sh8000_0000;
                end else begin
                    value = $urandom;
                end

                // Mostly a position inside the list; otherwise zero, somewhere past the end,
                // or anywhere in the field so that every position bit toggles.
                pick = $urandom_range(9);
                if (size_now > 0 && pick < 7) begin
                    pos = $urandom_range(size_now, 1);
                end else if (pick == 7) begin
                    pos = 0;
                end else if (pick == 8) begin
                    pos = $urandom_range(255, size_now + 1);
                end else begin
                    pos = $urandom_range(255, 0);
                end

                send_request(op, value, pos, 1'b0, STAT_OK, '0);
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Wait for every owed result, then leave room for anything extra to show up.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* bounded_doubly_linked_list.f */
hdl/bdll_pkg.sv
hdl/bdll_cell.sv
hdl/bounded_doubly_linked_list.sv
sim/bounded_doubly_linked_list_test.sv
